>>> design/lpse_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpse_pkg
// Shared types and constants of the LED pixel SPI symbol encoder.
// ---------------------------------------------------------------------------
package lpse_pkg;

   localparam int LPSE_MAX_PIXELS = 64;

   localparam int PIXEL_INDEX_W  = 6;
   localparam int COLOR_W        = 24;
   localparam int BYTE_W         = 8;
   localparam int BITS_PER_PIXEL = 24;
   localparam int BIT_CNT_W      = $clog2(BITS_PER_PIXEL);

   localparam logic [BYTE_W-1:0] SYM_ONE  = 8'hF8;
   localparam logic [BYTE_W-1:0] SYM_ZERO = 8'hC0;

   // Operation codes of an input item
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SEND  = 1'b1;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_BRIGHTNESS  = 2'd0;
   localparam logic [1:0] REG_COLOR_ORDER = 2'd1;
   localparam logic [1:0] REG_PIXEL_COUNT = 2'd2;

   localparam logic [7:0] BRIGHTNESS_RESET  = 8'd255;
   localparam logic [5:0] COLOR_ORDER_RESET = 6'd18;
   localparam logic [6:0] PIXEL_COUNT_RESET = 7'd64;

   // Command queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic                     op;
      logic [PIXEL_INDEX_W-1:0] pixel_index;
      logic [COLOR_W-1:0]       color_in;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] spi_byte;
      logic              last_of_pixel;
      logic              frame_end;
   } rsp_type;

   // Classified command: a packed store word for writes, an index for both
   typedef struct packed {
      logic                     op;
      logic [PIXEL_INDEX_W-1:0] idx;
      logic [COLOR_W-1:0]       word;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_push_type;

   typedef struct packed {
      logic               full;
      logic               not_empty;
      logic [Q_CNT_W-1:0] count;
   } q_status_type;

endpackage

>>> design/lpse_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpse_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lpse_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/lpse_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpse_front
// Accept items, scale and reorder write colours, push commands to the queue.
// ---------------------------------------------------------------------------
module lpse_front
   import lpse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  logic [7:0]   brightness,
   input  logic [5:0]   color_order,
   output q_push_type   q_push,
   input  q_status_type q_status
);

   // x / 255 for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

   function automatic logic [23:0] place(input logic [7:0] b, input logic [1:0] slot);
      logic [23:0] w;
      case (slot)
         2'd0:    w = {b, 16'd0};
         2'd1:    w = {8'd0, b, 8'd0};
         default: w = {16'd0, b};
      endcase
      return w;
   endfunction

   logic                     accept;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_op_ff;
   logic [PIXEL_INDEX_W-1:0] s1_idx_ff;
   logic [15:0]              s1_prod_ff [3];
   logic [1:0]               s1_slot_ff [3];
   logic [1:0]               rs, gs, bs;
   logic                     bad_order;
   logic [23:0]              word;

   assign req_ready = !s1_valid_ff || !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rs = color_order[5:4];
      gs = color_order[3:2];
      bs = color_order[1:0];
      bad_order = (rs == 2'd3) || (gs == 2'd3) || (bs == 2'd3) ||
                  (rs == gs) || (rs == bs) || (gs == bs);
      // fall back to GRB
      if (bad_order) begin
         rs = 2'd1;
         gs = 2'd0;
         bs = 2'd2;
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && q_status.full);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= req_data.op;
         s1_idx_ff     <= req_data.pixel_index;
         s1_prod_ff[0] <= 16'(req_data.color_in[23:16]) * 16'(brightness);
         s1_prod_ff[1] <= 16'(req_data.color_in[15:8]) * 16'(brightness);
         s1_prod_ff[2] <= 16'(req_data.color_in[7:0]) * 16'(brightness);
         s1_slot_ff[0] <= rs;
         s1_slot_ff[1] <= gs;
         s1_slot_ff[2] <= bs;
      end
   end

   assign word = place(div255(s1_prod_ff[0]), s1_slot_ff[0])
               | place(div255(s1_prod_ff[1]), s1_slot_ff[1])
               | place(div255(s1_prod_ff[2]), s1_slot_ff[2]);

   always_comb begin
      q_push.valid    = s1_valid_ff;
      q_push.cmd.op   = s1_op_ff;
      q_push.cmd.idx  = s1_idx_ff;
      q_push.cmd.word = word;
   end

endmodule

>>> design/lpse_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpse_queue
// Small register FIFO of classified commands between front and back.
// ---------------------------------------------------------------------------
module lpse_queue
   import lpse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_push_type   q_push,
   input  logic         pop,
   output cmd_type      head,
   output q_status_type q_status
);

   cmd_type            slots_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign do_push = q_push.valid && (count_ff != Q_CNT_W'(Q_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

   assign head = slots_ff[rd_ptr_ff];

   always_comb begin
      q_status.full      = (count_ff == Q_CNT_W'(Q_DEPTH));
      q_status.not_empty = (count_ff != '0);
      q_status.count     = count_ff;
   end

endmodule

>>> design/lpse_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpse_back
// Execute commands: store pixel words, serialise sends as SPI symbol bytes.
// ---------------------------------------------------------------------------
module lpse_back
   import lpse_pkg::*;
#(
   parameter int MAX_PIXELS = LPSE_MAX_PIXELS
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      head,
   input  q_status_type q_status,
   output logic         pop,
   input  logic [6:0]   pixel_count,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   // Only 2**PIXEL_INDEX_W pixels are addressable
   localparam int DEPTH = (MAX_PIXELS < (1 << PIXEL_INDEX_W)) ? MAX_PIXELS
                                                              : (1 << PIXEL_INDEX_W);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_SHIFT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [DEPTH-1:0]      stored_ff, stored_in;
   logic                  hit_ff, hit_in;
   logic                  last_pix_ff, last_pix_in;
   logic [COLOR_W-1:0]    shift_ff, shift_in;
   logic [BIT_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  in_range, wr_en, load, last_bit;
   logic [AW-1:0]         addr;
   logic [COLOR_W-1:0]    rd_data;

   assign addr     = head.idx[AW-1:0];
   assign in_range = ({1'b0, head.idx} < 7'(DEPTH));
   assign pop      = (state_ff == ST_IDLE) && q_status.not_empty;
   assign wr_en    = pop && (head.op == OP_WRITE) && in_range;
   assign load     = !rsp_valid_ff || rsp_ready;
   assign last_bit = (cnt_ff == BIT_CNT_W'(BITS_PER_PIXEL - 1));

   lpse_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (head.word),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      stored_in    = stored_ff;
      hit_in       = hit_ff;
      last_pix_in  = last_pix_ff;
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (head.op == OP_WRITE) begin
                  if (in_range) begin
                     stored_in[addr] = 1'b1;
                  end
               end else begin
                  hit_in      = in_range && stored_ff[addr];
                  last_pix_in = (({1'b0, head.idx} + 7'd1) == pixel_count);
                  state_in    = ST_READ;
               end
            end
         end
         ST_READ: begin
            shift_in = hit_ff ? rd_data : '0;
            cnt_in   = '0;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (load) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.spi_byte      = shift_ff[COLOR_W-1] ? SYM_ONE : SYM_ZERO;
               rsp_data_in.last_of_pixel = last_bit;
               rsp_data_in.frame_end     = last_bit && last_pix_ff;
               shift_in                  = {shift_ff[COLOR_W-2:0], 1'b0};
               cnt_in                    = cnt_ff + 1'b1;
               if (last_bit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stored_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      last_pix_ff <= last_pix_in;
      shift_ff    <= shift_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/led_pixel_spi_symbol_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_pixel_spi_symbol_encoder
// Scale, reorder and store RGB pixels; send stored pixels as SPI symbols.
// ---------------------------------------------------------------------------
// Path: a send passes the front register, the queue, the store read and the
// shift register before its first byte; a write passes the front register
// and the queue. Writes stream at one per cycle while the queue has room. A
// send holds the back end for queue pop, store read and 24 bytes, and longer while the sink stalls.
// Reset: synchronous, active high; registers return to brightness 255,
// order GRB, 64 pixels, and per-pixel valid bits make the store read as zero.
// ---------------------------------------------------------------------------
module led_pixel_spi_symbol_encoder
   import lpse_pkg::*;
#(
   parameter int MAX_PIXELS = LPSE_MAX_PIXELS
) (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]   brightness_ff;
   logic [5:0]   color_order_ff;
   logic [6:0]   pixel_count_ff;
   logic         csr_wr;
   logic [1:0]   csr_index;
   q_push_type   q_push;
   q_status_type q_status;
   cmd_type      q_head;
   logic         q_pop;

   // -----------------------------------------------------------------------
   // Configuration registers: write on the access phase, ignore unknown
   // indexes, keep only the register's own bits.
   // -----------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff  <= BRIGHTNESS_RESET;
         color_order_ff <= COLOR_ORDER_RESET;
         pixel_count_ff <= PIXEL_COUNT_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            REG_BRIGHTNESS:  brightness_ff  <= csr_pwdata[7:0];
            REG_COLOR_ORDER: color_order_ff <= csr_pwdata[5:0];
            REG_PIXEL_COUNT: pixel_count_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BRIGHTNESS:  csr_prdata = {24'd0, brightness_ff};
         REG_COLOR_ORDER: csr_prdata = {26'd0, color_order_ff};
         REG_PIXEL_COUNT: csr_prdata = {25'd0, pixel_count_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // -----------------------------------------------------------------------
   // Front: take each transfer, scale the channels (one multiplier per
   // channel, registered, then a reciprocal for /255) and pack the slots.
   // -----------------------------------------------------------------------
   lpse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .brightness  (brightness_ff),
      .color_order (color_order_ff),
      .q_push      (q_push),
      .q_status    (q_status)
   );

   // -----------------------------------------------------------------------
   // Queue: decouple the front from a back end busy serialising a send.
   // -----------------------------------------------------------------------
   lpse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (q_pop),
      .head     (q_head),
      .q_status (q_status)
   );

   // -----------------------------------------------------------------------
   // Back: write the store, or read it and shift out 24 symbol bytes, MSB
   // first, through an output register that holds while the sink stalls.
   // -----------------------------------------------------------------------
   lpse_back #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .q_status    (q_status),
      .pop         (q_pop),
      .pixel_count (pixel_count_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // -----------------------------------------------------------------------
   // Assertions
   // -----------------------------------------------------------------------
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_symbol_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.spi_byte == SYM_ONE) || (rsp_data.spi_byte == SYM_ZERO))
      else $error("result byte is not a symbol code");

   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.last_of_pixel)
      else $error("frame end flagged away from the last byte of a pixel");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (q_status.count <= Q_CNT_W'(Q_DEPTH)) && (q_status.full || !q_push.valid || req_ready))
      else $error("queue overfilled or front stalled with room left");

endmodule

>>> bench/spi_symbol_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spi_symbol_checker
// Watches the item, symbol and register ports of the SPI symbol encoder,
// keeps its own pixel store and registers, and compares each symbol.
// ---------------------------------------------------------------------------
module spi_symbol_checker
   import lpse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          symbols_owed
);

   logic [COLOR_W-1:0] pixel_mem [LPSE_MAX_PIXELS];
   logic [7:0]         brightness_q;
   logic [5:0]         order_q;
   logic [6:0]         chain_len_q;
   rsp_type            symbols_due [$];

   initial begin
      mismatch_count = 0;
      symbols_owed   = 0;
   end

   function automatic logic [7:0] scale_channel(logic [7:0] level, logic [7:0] bright);
      logic [15:0] product;
      product = 16'(level) * 16'(bright);
      return 8'(product / 16'd255);
   endfunction

   // Scale, then place each channel in its slot; slot 0 is the top byte.
   function automatic logic [COLOR_W-1:0] pack_pixel(logic [COLOR_W-1:0] colour,
                                                     logic [7:0] bright,
                                                     logic [5:0] order);
      logic [1:0]         r_slot;
      logic [1:0]         g_slot;
      logic [1:0]         b_slot;
      logic [COLOR_W-1:0] word;
      r_slot = order[5:4];
      g_slot = order[3:2];
      b_slot = order[1:0];
      // fall back to GRB on anything that is not a permutation
      if (r_slot == 2'd3 || g_slot == 2'd3 || b_slot == 2'd3 ||
          r_slot == g_slot || r_slot == b_slot || g_slot == b_slot) begin
         r_slot = 2'd1;
         g_slot = 2'd0;
         b_slot = 2'd2;
      end
      word = (24'(scale_channel(colour[23:16], bright)) << ((2 - r_slot) * 8))
           | (24'(scale_channel(colour[15:8], bright)) << ((2 - g_slot) * 8))
           | (24'(scale_channel(colour[7:0], bright)) << ((2 - b_slot) * 8));
      return word;
   endfunction

   task automatic note_mismatch(string what, int got, int want);
      $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type            want;
      logic [COLOR_W-1:0] word;
      if (reset) begin
         foreach (pixel_mem[i]) pixel_mem[i] = '0;
         brightness_q = BRIGHTNESS_RESET;
         order_q      = COLOR_ORDER_RESET;
         chain_len_q  = PIXEL_COUNT_RESET;
         symbols_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               {REG_BRIGHTNESS, 2'b00}:  brightness_q = csr_pwdata[7:0];
               {REG_COLOR_ORDER, 2'b00}: order_q      = csr_pwdata[5:0];
               {REG_PIXEL_COUNT, 2'b00}: chain_len_q  = csr_pwdata[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.op == OP_WRITE) begin
               pixel_mem[req_data.pixel_index] =
                  pack_pixel(req_data.color_in, brightness_q, order_q);
            end else begin
               word = pixel_mem[req_data.pixel_index];
               for (int k = 0; k < BITS_PER_PIXEL; k++) begin
                  want.spi_byte      = word[COLOR_W-1-k] ? SYM_ONE : SYM_ZERO;
                  want.last_of_pixel = (k == BITS_PER_PIXEL - 1);
                  want.frame_end     = (k == BITS_PER_PIXEL - 1) &&
                                       (int'(req_data.pixel_index) + 1 == int'(chain_len_q));
                  symbols_due.push_back(want);
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (symbols_due.size() == 0) begin
               note_mismatch("symbol with none due", rsp_data.spi_byte, 0);
            end else begin
               want = symbols_due.pop_front();
               if (rsp_data.spi_byte !== want.spi_byte)
                  note_mismatch("spi_byte", rsp_data.spi_byte, want.spi_byte);
               if (rsp_data.last_of_pixel !== want.last_of_pixel)
                  note_mismatch("last_of_pixel", rsp_data.last_of_pixel, want.last_of_pixel);
               if (rsp_data.frame_end !== want.frame_end)
                  note_mismatch("frame_end", rsp_data.frame_end, want.frame_end);
            end
         end
      end
      symbols_owed = symbols_due.size();
   end

endmodule

>>> bench/led_pixel_spi_symbol_encoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_pixel_spi_symbol_encoder_test
// Drives pixel writes and sends into the encoder under several register
// settings and handshake idling patterns; the checker predicts each symbol.
// ---------------------------------------------------------------------------
module led_pixel_spi_symbol_encoder_test;
   import lpse_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 76;
   localparam int N_PHASES     = 6;
   localparam int MAX_GAP      = 10;
   localparam int LONG_HOLD    = 350;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = 4'h0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          mismatches;
   int          owed;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_left     = 0;
   int          cycle_count   = 0;
   logic [6:0]  chain_length  = PIXEL_COUNT_RESET;
   logic [5:0]  recent_index  = '0;

   always #6 clock = ~clock;

   led_pixel_spi_symbol_encoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   spi_symbol_checker u_symbol_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatches),
      .symbols_owed   (owed)
   );

   // Abort a hung run; the limit is many times the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Symbol receiver: honour a long hold first, else stall at random.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Length of an idle gap: keep adding cycles, up to MAX_GAP, while the dice say idle.
   function automatic int pick_gap(int pct);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < pct) gap++;
      return gap;
   endfunction

   // Offer one item and hold it until its transfer; enter and leave at a
   // falling edge. Valid stays high afterwards, so back-to-back items
   // need only a payload change.
   task automatic offer(input req_type item);
      int gap;
      gap = pick_gap(send_idle_pct);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (item.op == OP_WRITE) recent_index = item.pixel_index;
   endtask

   task automatic offer_fields(input logic op, input logic [5:0] index,
                               input logic [23:0] colour);
      req_type item;
      item.op          = op;
      item.pixel_index = index;
      item.color_in    = colour;
      offer(item);
   endtask

   // Mostly writes followed by sends of the same pixel, with sends of the
   // chain's last pixel mixed in so that frame end comes up often.
   function automatic req_type random_item();
      req_type item;
      int      pick;
      item.op = ($urandom_range(99) < 45) ? OP_SEND : OP_WRITE;
      pick = $urandom_range(9);
      if (pick < 3)      item.pixel_index = recent_index;
      else if (pick < 5) item.pixel_index = 6'(chain_length - 7'd1);
      else               item.pixel_index = 6'($urandom_range(63));
      pick = $urandom_range(9);
      if (pick == 0)      item.color_in = 24'h000000;
      else if (pick == 1) item.color_in = 24'hFFFFFF;
      else                item.color_in = 24'($urandom);
      return item;
   endfunction

   // Drop valid, wait until every symbol has arrived, then let queued
   // writes land before anything touches the registers.
   task automatic settle();
      req_valid = 1'b0;
      wait (owed == 0);
      @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Register write: setup, then access until pready.
   task automatic write_reg(input logic [1:0] reg_index, input logic [31:0] value);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {reg_index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (reg_index == REG_PIXEL_COUNT) chain_length = value[6:0];
   endtask

   // One register setting per phase; extremes first, then random ones and a fixed one in phase 4.
   task automatic apply_setting(input int phase);
      case (phase)
         0: begin
            write_reg(REG_BRIGHTNESS, 32'd255);
            write_reg(REG_COLOR_ORDER, 32'd6);       // RGB
            write_reg(REG_PIXEL_COUNT, 32'd1);
         end
         1: begin
            write_reg(REG_BRIGHTNESS, 32'd0);
            write_reg(REG_COLOR_ORDER, 32'd36);      // BGR
            write_reg(REG_PIXEL_COUNT, 32'd64);
         end
         2: begin
            write_reg(REG_BRIGHTNESS, 32'd1);
            write_reg(REG_COLOR_ORDER, 32'd20);      // two channels share a slot
            write_reg(REG_PIXEL_COUNT, 32'd127);
         end
         4: begin
            write_reg(REG_BRIGHTNESS, 32'd128);
            write_reg(REG_COLOR_ORDER, 32'd9);
            write_reg(REG_PIXEL_COUNT, 32'd32);
         end
         default: begin
            write_reg(REG_BRIGHTNESS, 32'($urandom_range(255)));
            write_reg(REG_COLOR_ORDER, 32'($urandom_range(63)));
            write_reg(REG_PIXEL_COUNT, 32'($urandom_range(127)));
         end
      endcase
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed part under reset settings (full brightness, GRB, 64 pixels).
      // Send an unwritten pixel first: the store must read as zero.
      offer_fields(OP_SEND, 6'd5, 24'h000000);
      offer_fields(OP_WRITE, 6'd0, 24'hFFFFFF);
      offer_fields(OP_SEND, 6'd0, 24'h000000);
      offer_fields(OP_WRITE, 6'd63, 24'h000000);
      offer_fields(OP_SEND, 6'd63, 24'hFFFFFF);  // last pixel of the chain
      offer_fields(OP_WRITE, 6'd1, 24'h123456);
      offer_fields(OP_SEND, 6'd1, 24'h000000);
      offer_fields(OP_WRITE, 6'd2, 24'hFF0000);
      offer_fields(OP_SEND, 6'd2, 24'h000000);
      offer_fields(OP_WRITE, 6'd3, 24'h00FF00);
      offer_fields(OP_SEND, 6'd3, 24'h000000);
      offer_fields(OP_WRITE, 6'd4, 24'h0000FF);
      offer_fields(OP_SEND, 6'd4, 24'h000000);
      settle();

      // Slot value 3 forces GRB, junk above the field must be masked off,
      // and a zero chain length never flags frame end.
      write_reg(REG_COLOR_ORDER, 32'd63);
      write_reg(REG_BRIGHTNESS, 32'hFFFF_FF80);
      write_reg(REG_PIXEL_COUNT, 32'd0);
      offer_fields(OP_WRITE, 6'd6, 24'hA5C3F0);
      offer_fields(OP_SEND, 6'd6, 24'h000000);
      offer_fields(OP_SEND, 6'd63, 24'h000000);
      offer_fields(OP_WRITE, 6'd63, 24'hFFFFFF);
      offer_fields(OP_SEND, 6'd63, 24'h000000);
      offer_fields(OP_WRITE, 6'd0, 24'h808080);
      offer_fields(OP_SEND, 6'd0, 24'h000000);
      settle();

      // Random part: two phases per idling pattern, each with fresh settings.
      for (int phase = 0; phase < N_PHASES; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct = 56;
            end
            1: begin
               send_idle_pct = 56;
               recv_idle_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         apply_setting(phase);
         // Hold the receiver off for a long stretch while items keep coming,
         // so the command queue fills and req_ready drops.
         if (phase == 2) hold_left = LONG_HOLD;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Pause the sender mid-phase until every symbol has come out.
            if (phase == 1 && n == PHASE_ITEMS / 2) settle();
            offer(random_item());
         end
         settle();
      end

      req_valid = 1'b0;
      wait (owed == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> files.f
design/lpse_pkg.sv
design/lpse_ram.sv
design/lpse_front.sv
design/lpse_queue.sv
design/lpse_back.sv
design/led_pixel_spi_symbol_encoder.sv
bench/spi_symbol_checker.sv
bench/led_pixel_spi_symbol_encoder_test.sv
